### rtl/arp_pkg.sv
// shared types, codes and constants for the arpeggiator step sequencer
package arp_pkg;

  localparam int MaxZones        = 16;
  localparam int FracBitsDefault = 8;
  localparam int AccWidth        = 25;
  localparam int RandomTries     = 16;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_ZONE  = 2'd1;
  localparam logic [1:0] ACT_COUNT = 2'd2;

  localparam logic [2:0] MODE_PLACED = 3'd0;
  localparam logic [2:0] MODE_UP     = 3'd1;
  localparam logic [2:0] MODE_DOWN   = 3'd2;
  localparam logic [2:0] MODE_LR     = 3'd3;
  localparam logic [2:0] MODE_RL     = 3'd4;
  localparam logic [2:0] MODE_BU     = 3'd5;
  localparam logic [2:0] MODE_TD     = 3'd6;
  localparam logic [2:0] MODE_RANDOM = 3'd7;

  localparam logic [2:0] REG_ENABLE   = 3'd0;
  localparam logic [2:0] REG_MODE     = 3'd1;
  localparam logic [2:0] REG_PENDULUM = 3'd2;
  localparam logic [2:0] REG_RATCHET  = 3'd3;
  localparam logic [2:0] REG_INTERVAL = 3'd4;
  localparam logic [2:0] REG_FLOOR    = 3'd5;
  localparam logic [2:0] REG_SEED     = 3'd6;

  // commands from the controller to the datapath
  typedef struct packed {
    logic zone_write;
    logic count_write;
    logic sort_start;
    logic sort_step;
    logic sort_done;
    logic mod_step;
    logic acc_update;
    logic emit;
    logic advance;
    logic rand_step;
    logic rand_take;
    logic rand_give_up;
  } arp_cmd_t;

  typedef struct packed {
    logic run_ok;
    logic need_rebuild;
    logic hit;
    logic ratchet_wrap;
    logic short_seq;
    logic is_random;
    logic sort_last;
    logic mod_last;
    logic rand_differs;
  } arp_status_t;

  function automatic logic [15:0] sort_key(input logic [2:0] mode, input logic [6:0] note,
                                           input logic [7:0] order, input logic [15:0] x,
                                           input logic [15:0] y);
    logic [15:0] k;
    case (mode)
      MODE_PLACED: k = {8'd0, order};
      MODE_UP:     k = {9'd0, note};
      MODE_DOWN:   k = {9'd0, ~note};
      MODE_LR:     k = x;
      MODE_RL:     k = ~x;
      MODE_BU:     k = ~y;
      MODE_TD:     k = y;
      default:     k = 16'd0;
    endcase
    return k;
  endfunction

endpackage

### rtl/arpeggiator_step_sequencer.sv
// arpeggiator step sequencer top level
// zone and count writes are taken from idle; a tick runs the accumulate and hit states, plus on a rebuild
// the sort (one insertion per cycle, then 4 steps folding position into the length)
// and random draws (up to 16) when random mode moves the position
// an event shows in the cycle after the hit and holds until taken; a hit waits while one is held
// synchronous reset clears control state; zone table and play order are undefined until written
module arpeggiator_step_sequencer #(
  parameter int INTERVAL_FRACTION_BITS = arp_pkg::FracBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [3:0]  zone_slot,
  input  logic [6:0]  note_in,
  input  logic [7:0]  placement_order,
  input  logic [15:0] x_pos,
  input  logic [15:0] y_pos,
  input  logic [4:0]  zone_total,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  note_out,
  output logic [3:0]  zone_index,
  output logic [6:0]  velocity_percent
);
  import arp_pkg::*;

  arp_cmd_t    cmd;
  arp_status_t st;
  logic        cfg_written, seed_written, arp_enable, pendulum_enable;
  logic [2:0]  play_mode;
  logic [3:0]  ratchet_repeats;
  logic [23:0] hit_interval_q8;
  logic [6:0]  velocity_floor;
  logic [31:0] random_seed;
  logic        out_busy;

  assign out_valid = out_busy;

  arp_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_written, .seed_written, .arp_enable, .play_mode, .pendulum_enable,
    .ratchet_repeats, .hit_interval_q8, .velocity_floor, .random_seed
  );

  arp_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .action, .out_busy, .st, .cmd
  );

  arp_dpath #(
    .INTERVAL_FRACTION_BITS(INTERVAL_FRACTION_BITS)
  ) u_dpath (
    .clk, .rst, .cmd, .st, .cfg_written, .seed_written, .arp_enable, .play_mode,
    .pendulum_enable, .ratchet_repeats, .hit_interval_q8, .velocity_floor, .random_seed,
    .zone_slot, .note_in, .placement_order, .x_pos, .y_pos, .zone_total,
    .out_take(out_busy && !out_stall), .out_busy, .note_out, .zone_index,
    .velocity_percent
  );
endmodule

### rtl/arp_regs.sv
// configuration register file on the apb-style port
module arp_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic        cfg_written,
  output logic        seed_written,
  output logic        arp_enable,
  output logic [2:0]  play_mode,
  output logic        pendulum_enable,
  output logic [3:0]  ratchet_repeats,
  output logic [23:0] hit_interval_q8,
  output logic [6:0]  velocity_floor,
  output logic [31:0] random_seed
);
  import arp_pkg::*;

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite && (paddr[1:0] == 2'd0) && (idx <= REG_SEED);
  assign cfg_written  = wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      arp_enable      <= 1'b0;
      play_mode       <= MODE_PLACED;
      pendulum_enable <= 1'b0;
      ratchet_repeats <= 4'd0;
      hit_interval_q8 <= 24'd25600;
      velocity_floor  <= 7'd0;
      random_seed     <= 32'd1;
      seed_written    <= 1'b0;
    end else begin
      // registered so the generator loads the new seed value
      seed_written <= wr && (idx == REG_SEED);
      if (wr) begin
        case (idx)
          REG_ENABLE:   arp_enable      <= pwdata[0];
          REG_MODE:     play_mode       <= pwdata[2:0];
          REG_PENDULUM: pendulum_enable <= pwdata[0];
          REG_RATCHET:  ratchet_repeats <= pwdata[3:0];
          REG_INTERVAL: hit_interval_q8 <= pwdata[23:0];
          REG_FLOOR:    velocity_floor  <= pwdata[6:0];
          REG_SEED:     random_seed     <= pwdata;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (idx)
      REG_ENABLE:   prdata = {31'd0, arp_enable};
      REG_MODE:     prdata = {29'd0, play_mode};
      REG_PENDULUM: prdata = {31'd0, pendulum_enable};
      REG_RATCHET:  prdata = {28'd0, ratchet_repeats};
      REG_INTERVAL: prdata = {8'd0, hit_interval_q8};
      REG_FLOOR:    prdata = {25'd0, velocity_floor};
      REG_SEED:     prdata = random_seed;
      default:      prdata = 32'd0;
    endcase
  end
endmodule

### rtl/arp_ctrl.sv
// sequencing state machine: item decode, rebuild sort, hit, advance
module arp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          action,
  input  logic                out_busy,
  input  arp_pkg::arp_status_t st,
  output arp_pkg::arp_cmd_t    cmd
);
  import arp_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SORT = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_HIT  = 3'd3;
  localparam logic [2:0] S_RAND = 3'd4;
  localparam logic [2:0] S_RCHK = 3'd5;
  localparam logic [2:0] S_MOD  = 3'd6;

  localparam int TryW = $clog2(RandomTries + 1);

  logic [2:0]      state, state_next;
  logic [TryW-1:0] tries, tries_next;

  // accept only while idle; the output register lets items in while an event waits
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    tries_next = tries;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (action)
            ACT_ZONE:  cmd.zone_write  = 1'b1;
            ACT_COUNT: cmd.count_write = 1'b1;
            ACT_TICK: begin
              if (st.run_ok) begin
                if (st.need_rebuild) begin
                  cmd.sort_start = 1'b1;
                  state_next     = S_SORT;
                end else begin
                  state_next = S_ACC;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_SORT: begin
        cmd.sort_step = 1'b1;
        if (st.sort_last) begin
          cmd.sort_done = 1'b1;
          state_next    = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (st.mod_last) state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc_update = 1'b1;
        state_next     = S_HIT;
      end
      S_HIT: begin
        // a hit waits here until the previous event has been taken
        if (!st.hit) begin
          state_next = S_IDLE;
        end else if (!out_busy) begin
          state_next = S_IDLE;
          cmd.emit   = 1'b1;
          if (st.ratchet_wrap && !st.short_seq) begin
            if (st.is_random) begin
              tries_next = '0;
              state_next = S_RAND;
            end else begin
              cmd.advance = 1'b1;
            end
          end
        end
      end
      S_RAND: begin
        cmd.rand_step = 1'b1;
        tries_next    = tries + 1'b1;
        state_next    = S_RCHK;
      end
      S_RCHK: begin
        if (st.rand_differs) begin
          cmd.rand_take = 1'b1;
          state_next    = S_IDLE;
        end else if (tries == TryW'(RandomTries)) begin
          cmd.rand_give_up = 1'b1;
          state_next       = S_IDLE;
        end else begin
          state_next = S_RAND;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tries <= '0;
    end else begin
      state <= state_next;
      tries <= tries_next;
    end
  end
endmodule

### rtl/arp_dpath.sv
// datapath: zone table, play order, accumulator, position and generator
module arp_dpath #(
  parameter int INTERVAL_FRACTION_BITS = arp_pkg::FracBitsDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  arp_pkg::arp_cmd_t    cmd,
  output arp_pkg::arp_status_t st,
  input  logic                 cfg_written,
  input  logic                 seed_written,
  input  logic                 arp_enable,
  input  logic [2:0]           play_mode,
  input  logic                 pendulum_enable,
  input  logic [3:0]           ratchet_repeats,
  input  logic [23:0]          hit_interval_q8,
  input  logic [6:0]           velocity_floor,
  input  logic [31:0]          random_seed,
  input  logic [3:0]           zone_slot,
  input  logic [6:0]           note_in,
  input  logic [7:0]           placement_order,
  input  logic [15:0]          x_pos,
  input  logic [15:0]          y_pos,
  input  logic [4:0]           zone_total,
  input  logic                 out_take,
  output logic                 out_busy,
  output logic [6:0]           note_out,
  output logic [3:0]           zone_index,
  output logic [6:0]           velocity_percent
);
  import arp_pkg::*;

  localparam int MAX_ZONES = MaxZones;
  localparam int IW = $clog2(MAX_ZONES);
  localparam int CW = $clog2(MAX_ZONES + 1);
  localparam int PW = 32 + CW;
  localparam int MW = IW + CW;
  localparam logic [AccWidth-1:0] AccMax = {AccWidth{1'b1}};
  localparam logic [AccWidth-1:0] AccInc = AccWidth'(1) << INTERVAL_FRACTION_BITS;

  logic [6:0]  z_note  [MAX_ZONES];
  logic [7:0]  z_order [MAX_ZONES];
  logic [15:0] z_x     [MAX_ZONES];
  logic [15:0] z_y     [MAX_ZONES];
  logic [IW-1:0] order_q [MAX_ZONES];

  logic [CW-1:0] zone_count, built_count;
  logic          rebuild_pending;
  logic [IW-1:0] position;
  logic          moving_down;
  logic [3:0]    ratchet_hits;
  logic [AccWidth-1:0] acc;
  logic [31:0]   rng;
  logic [CW-1:0] sort_i;
  logic [CW-1:0] mod_k;
  logic [IW-1:0] draw;

  logic [CW-1:0]       total_sat;
  logic [AccWidth-1:0] interval, acc_sum;
  logic [31:0]         x1, x2, x3;
  logic [IW-1:0]       cur_zone;
  logic [IW-1:0]       new_idx;
  logic [15:0]         new_key;
  logic [MAX_ZONES-1:0] greater;
  logic [IW-1:0]       ins_pos;
  logic [6:0]          floor_c;
  logic [PW-1:0]       prod;
  logic [MW-1:0]       mod_div;

  assign total_sat = (zone_total > 5'(MAX_ZONES)) ? CW'(MAX_ZONES) : CW'(zone_total);
  assign interval  = (hit_interval_q8 == 24'd0) ? AccWidth'(1) : AccWidth'(hit_interval_q8);
  assign acc_sum   = (acc > AccMax - AccInc) ? AccMax : acc + AccInc;
  assign cur_zone  = order_q[position];
  assign x1 = rng ^ (rng << 13);
  assign x2 = x1 ^ (x1 >> 17);
  assign x3 = x2 ^ (x2 << 5);
  assign prod = PW'(x3) * PW'(built_count);
  assign floor_c = (velocity_floor > 7'd100) ? 7'd100 : velocity_floor;
  // restoring reduction of the position, one shifted length per step
  assign mod_div = MW'(zone_count) << mod_k;

  // insertion sort, one element per cycle: shift larger keys up by one
  assign new_idx = sort_i[IW-1:0];
  assign new_key = sort_key(play_mode, z_note[new_idx], z_order[new_idx], z_x[new_idx],
                            z_y[new_idx]);
  always_comb begin
    for (int j = 0; j < MAX_ZONES; j++) begin
      greater[j] = (CW'(j) < sort_i) &&
                   (sort_key(play_mode, z_note[order_q[j]], z_order[order_q[j]],
                             z_x[order_q[j]], z_y[order_q[j]]) > new_key);
    end
    ins_pos = new_idx;
    for (int j = MAX_ZONES - 1; j >= 0; j--) begin
      if (greater[j]) ins_pos = IW'(j);
    end
  end

  always_comb begin
    st.run_ok       = arp_enable && (zone_count != '0);
    st.need_rebuild = rebuild_pending || (zone_count != built_count);
    st.hit          = acc >= interval;
    st.ratchet_wrap = ratchet_hits >= ratchet_repeats;
    st.short_seq    = built_count <= CW'(1);
    st.is_random    = play_mode == MODE_RANDOM;
    st.sort_last    = sort_i == zone_count - CW'(1);
    st.mod_last     = mod_k == '0;
    st.rand_differs = draw != position;
  end

  always_ff @(posedge clk) begin
    if (cmd.zone_write) begin
      z_note[zone_slot[IW-1:0]]  <= note_in;
      z_order[zone_slot[IW-1:0]] <= placement_order;
      z_x[zone_slot[IW-1:0]]     <= x_pos;
      z_y[zone_slot[IW-1:0]]     <= y_pos;
    end
    if (cmd.sort_step) begin
      for (int j = 0; j < MAX_ZONES; j++) begin
        if (greater[j] && j + 1 < MAX_ZONES) order_q[j+1] <= order_q[j];
      end
      order_q[ins_pos] <= new_idx;
    end
    if (cmd.rand_step) draw <= IW'(prod[PW-1:32]);
    if (cmd.emit) begin
      note_out         <= z_note[cur_zone];
      zone_index       <= 4'(cur_zone);
      velocity_percent <= (floor_c > 7'd80) ? floor_c : 7'd80;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_count      <= '0;
      built_count     <= '0;
      rebuild_pending <= 1'b1;
      position        <= '0;
      moving_down     <= 1'b0;
      ratchet_hits    <= 4'd0;
      acc             <= '0;
      rng             <= 32'd1;
      sort_i          <= '0;
      mod_k           <= '0;
      out_busy        <= 1'b0;
    end else begin
      if (cfg_written) rebuild_pending <= 1'b1;
      if (seed_written) rng <= (random_seed == 32'd0) ? 32'd1 : random_seed;
      if (cmd.zone_write) rebuild_pending <= 1'b1;
      if (cmd.count_write) begin
        if (total_sat != zone_count) rebuild_pending <= 1'b1;
        zone_count <= total_sat;
      end
      if (cmd.sort_start) begin
        sort_i <= '0;
        mod_k  <= CW'(IW - 1);
      end
      if (cmd.sort_step) sort_i <= sort_i + CW'(1);
      if (cmd.sort_done) begin
        built_count     <= zone_count;
        rebuild_pending <= 1'b0;
      end
      if (cmd.mod_step) begin
        if (MW'(position) >= mod_div) position <= IW'(MW'(position) - mod_div);
        mod_k <= mod_k - CW'(1);
      end
      if (cmd.acc_update) acc <= acc_sum;
      if (cmd.emit) begin
        acc      <= acc - interval;
        out_busy <= 1'b1;
        if (ratchet_hits >= ratchet_repeats) ratchet_hits <= 4'd0;
        else ratchet_hits <= ratchet_hits + 4'd1;
      end else if (out_take) begin
        out_busy <= 1'b0;
      end
      if (cmd.advance) begin
        if (pendulum_enable) begin
          if (!moving_down) begin
            if (CW'(position) + CW'(1) >= built_count) begin
              moving_down <= 1'b1;
              position    <= IW'(built_count - CW'(2));
            end else begin
              position <= position + IW'(1);
            end
          end else if (position == '0) begin
            moving_down <= 1'b0;
            position    <= IW'(1);
          end else begin
            position <= position - IW'(1);
          end
        end else if (CW'(position) + CW'(1) >= built_count) begin
          position <= '0;
        end else begin
          position <= position + IW'(1);
        end
      end
      if (cmd.rand_step) rng <= x3;
      if (cmd.rand_take) position <= draw;
      if (cmd.rand_give_up) begin
        if (CW'(position) + CW'(1) >= built_count) position <= '0;
        else position <= position + IW'(1);
      end
    end
  end
endmodule
